@@ design/skf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  // Gain is always unsigned Q0.16.
  localparam int GAIN_BITS = 16;

  // Register indexes on the configuration port.
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_MEAS_NOISE  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PROC_NOISE  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_START_EST   = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_START_VAR   = 2'd3;

  // Reset values of the noise registers, in whole units.
  localparam int MEAS_NOISE_DEF = 100;
  localparam int PROC_NOISE_DEF = 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the item and the starting state
    logic prep;       // form P + R and the innovation
    logic div_step;   // one restoring division step
    logic mul_start;  // latch the gain and set up both multipliers
    logic mul_step;   // one shift-add multiply step
    logic finish;     // form results, update state and output registers
  } skf_cmd_t;

endpackage

`default_nettype wire

@@ design/skf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skf_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output skf_pkg::skf_cmd_t     cmd_o
);
  import skf_pkg::*;

  localparam int DIV_STEPS = GAIN_BITS + 1;
  localparam int MUL_STEPS = GAIN_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PREP   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MSTART = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer: one item at a time through division, then both multiplies.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(DIV_STEPS - 1)) begin
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        cmd_o.mul_start = 1'b1;
        cnt_d           = '0;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(MUL_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ design/skf_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module skf_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire skf_pkg::skf_cmd_t             cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0]  sample_i,
  input  wire logic                          restart_i,
  input  wire logic [DATA_WIDTH-1:0]         meas_noise_i,
  input  wire logic [DATA_WIDTH-1:0]         proc_noise_i,
  input  wire logic [DATA_WIDTH-1:0]         start_est_i,
  input  wire logic [DATA_WIDTH-1:0]         start_var_i,
  output logic signed [DATA_WIDTH-1:0]       estimate_o,
  output logic [DATA_WIDTH-1:0]              error_variance_o,
  output logic [skf_pkg::GAIN_BITS-1:0]      gain_o
);
  import skf_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int QW  = GAIN_BITS + 1;
  localparam int AW1 = DW + 1 + GAIN_BITS;
  localparam int AW2 = DW + GAIN_BITS;
  localparam logic [DW-1:0] VAR_RST = DW'(64'd1 << FRAC_BITS);

  // Filter state.
  logic [DW-1:0] est_q, var_q;

  // Per-item working registers.
  logic [DW-1:0]        p_q, e_q, smp_q;
  logic [DW:0]          den_q, mag_q, rem_q;
  logic                 neg_q, nb_q;
  logic [QW-1:0]        quo_q;
  logic [GAIN_BITS-1:0] gain_q, gsh_q;
  logic [AW1-1:0]       mc1_q, acc1_q;
  logic [AW2-1:0]       mc2_q, acc2_q;

  // Output registers.
  logic [DW-1:0]        est_out_q, var_out_q;
  logic [GAIN_BITS-1:0] gain_out_q;

  logic [DW:0]          innov;
  logic [DW+1:0]        trial;
  logic [GAIN_BITS-1:0] gain_w;
  logic [DW:0]          delta;
  logic [DW+1:0]        delta_ext, est_sum;
  logic [DW-1:0]        est_sat;
  logic [DW:0]          newp;
  logic [DW-1:0]        var_sat;

  // Innovation, one bit wider than the data.
  assign innov = {smp_q[DW-1], smp_q} - {e_q[DW-1], e_q};

  // Division step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, nb_q};

  // Gain from the quotient: a zero divisor gives zero, a ratio of one saturates.
  always_comb begin
    if (den_q == '0) begin
      gain_w = '0;
    end else if (quo_q[QW-1]) begin
      gain_w = '1;
    end else begin
      gain_w = quo_q[GAIN_BITS-1:0];
    end
  end

  // Estimate update with saturation to the signed range.
  assign delta     = acc1_q[AW1-1:GAIN_BITS];
  assign delta_ext = neg_q ? (~{1'b0, delta} + 1'b1) : {1'b0, delta};
  assign est_sum   = {{2{e_q[DW-1]}}, e_q} + delta_ext;
  always_comb begin
    if ((est_sum[DW+1] != est_sum[DW]) || (est_sum[DW] != est_sum[DW-1])) begin
      est_sat = est_sum[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      est_sat = est_sum[DW-1:0];
    end
  end

  // Variance update; gain * P never exceeds P, so only the top can overflow.
  assign newp    = {1'b0, p_q} - {1'b0, acc2_q[AW2-1:GAIN_BITS]} + {1'b0, proc_noise_i};
  assign var_sat = newp[DW] ? '1 : newp[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
      var_q <= VAR_RST;
    end else if (cmd_i.finish) begin
      est_q <= est_sat;
      var_q <= var_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    // Capture the item; a restart takes the start registers instead of the state.
    if (cmd_i.load) begin
      smp_q <= sample_i;
      if (restart_i) begin
        p_q <= start_var_i;
        e_q <= start_est_i;
      end else begin
        p_q <= var_q;
        e_q <= est_q;
      end
    end
    // Denominator, innovation magnitude and division setup.
    if (cmd_i.prep) begin
      den_q <= {1'b0, p_q} + {1'b0, meas_noise_i};
      neg_q <= innov[DW];
      mag_q <= innov[DW] ? (~innov + 1'b1) : innov;
      rem_q <= {2'b00, p_q[DW-1:1]};
      nb_q  <= p_q[0];
      quo_q <= '0;
    end
    // Restoring division of P * 2^16 by P + R.
    if (cmd_i.div_step) begin
      nb_q <= 1'b0;
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial[DW:0] - den_q;
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DW:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
    // Two shift-add multipliers run side by side over the gain bits.
    if (cmd_i.mul_start) begin
      gain_q <= gain_w;
      gsh_q  <= gain_w;
      mc1_q  <= AW1'(mag_q);
      mc2_q  <= AW2'(p_q);
      acc1_q <= '0;
      acc2_q <= '0;
    end
    if (cmd_i.mul_step) begin
      if (gsh_q[0]) begin
        acc1_q <= acc1_q + mc1_q;
        acc2_q <= acc2_q + mc2_q;
      end
      mc1_q <= {mc1_q[AW1-2:0], 1'b0};
      mc2_q <= {mc2_q[AW2-2:0], 1'b0};
      gsh_q <= {1'b0, gsh_q[GAIN_BITS-1:1]};
    end
    // Result item.
    if (cmd_i.finish) begin
      est_out_q  <= est_sat;
      var_out_q  <= var_sat;
      gain_out_q <= gain_q;
    end
  end

  assign estimate_o       = est_out_q;
  assign error_variance_o = var_out_q;
  assign gain_o           = gain_out_q;

endmodule

`default_nettype wire

@@ design/scalar_kalman_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Scalar Kalman filter for a random-walk signal in fixed point (Q16.16 by
// default). Each input item carries a signed sample and a restart flag; the
// block returns one result item with the new estimate, the new error variance
// and the gain P/(P+R) in unsigned Q0.16. A restart reloads estimate and
// variance from the start registers before the update. Estimate and variance
// saturate at the limits of their range. Registers 0 to 3 are measurement
// noise R, process noise Q, start estimate and start variance; write them only
// while the block is idle. Each item passes through a setup step, a restoring
// divider that yields one gain bit per cycle, a multiplier setup step, two
// shift-add multipliers that take one gain bit per cycle, and an update step.
// The next item is accepted only after the update of the last one, so items
// never overlap. Input ready is high only between items; a finished result
// waits in an output register, and the update of the following item stalls
// until that result has been taken.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [skf_pkg::REG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0]             cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]      sample_i,
  input  wire logic                              restart_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [DATA_WIDTH-1:0]           estimate_o,
  output logic [DATA_WIDTH-1:0]                  error_variance_o,
  output logic [skf_pkg::GAIN_BITS-1:0]          gain_o
);
  import skf_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MEAS_RST =
    DATA_WIDTH'(64'(MEAS_NOISE_DEF) << FRAC_BITS);
  localparam logic [DATA_WIDTH-1:0] PROC_RST =
    DATA_WIDTH'(64'(PROC_NOISE_DEF) << FRAC_BITS);
  localparam logic [DATA_WIDTH-1:0] VAR_RST = DATA_WIDTH'(64'd1 << FRAC_BITS);

  logic [DATA_WIDTH-1:0] meas_q, proc_q, sest_q, svar_q;
  skf_cmd_t              cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q <= MEAS_RST;
      proc_q <= PROC_RST;
      sest_q <= '0;
      svar_q <= VAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MEAS_NOISE: meas_q <= cfg_wdata_i;
        REG_PROC_NOISE: proc_q <= cfg_wdata_i;
        REG_START_EST:  sest_q <= cfg_wdata_i;
        REG_START_VAR:  svar_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  skf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sample_i         (sample_i),
    .restart_i        (restart_i),
    .meas_noise_i     (meas_q),
    .proc_noise_i     (proc_q),
    .start_est_i      (sest_q),
    .start_var_i      (svar_q),
    .estimate_o       (estimate_o),
    .error_variance_o (error_variance_o),
    .gain_o           (gain_o)
  );

endmodule

`default_nettype wire

@@ test/tb_scalar_kalman_filter.sv @@
`timescale 1ns / 1ps

module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int DW = 32;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES = 8;
  localparam int LONG_HOLD = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] GAIN_MAX = (64'd1 << GAIN_BITS) - 64'd1;
  localparam logic [63:0] VAR_MAX = (64'd1 << DW) - 64'd1;
  localparam logic signed [63:0] EST_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] EST_MIN = -(64'sd1 <<< (DW - 1));

  typedef struct packed {
    logic signed [DW-1:0] sample;
    logic                 restart;
  } sample_item_t;

  typedef struct packed {
    logic signed [DW-1:0] estimate;
    logic [DW-1:0]        variance;
    logic [GAIN_BITS-1:0] gain;
  } filter_update_t;

  // Block ports; every input starts at a known value.
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_idx_i = '0;
  logic [DW-1:0]           cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [DW-1:0]    sample_i = '0;
  logic                    restart_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DW-1:0]    estimate_o;
  logic [DW-1:0]           error_variance_o;
  logic [GAIN_BITS-1:0]    gain_o;

  // Mirror of the registers and of the filter state.
  logic [DW-1:0]        meas_noise_reg = 32'd100 << 16;
  logic [DW-1:0]        proc_noise_reg = 32'd1 << 16;
  logic signed [DW-1:0] start_est_reg = '0;
  logic [DW-1:0]        start_var_reg = 32'd1 << 16;
  logic signed [DW-1:0] est_state = '0;
  logic [DW-1:0]        var_state = 32'd1 << 16;

  sample_item_t   sample_queue[$];
  filter_update_t predicted_updates[$];
  sample_item_t   next_item;
  filter_update_t want;

  int unsigned send_idle_max = 14;
  int unsigned recv_idle_max = 14;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned hold_len;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned restarts_seen = 0;
  int unsigned settings_loaded = 0;
  int unsigned var_saturations = 0;
  int unsigned gain_peak = 0;
  int unsigned gain_floor = 65535;

  scalar_kalman_filter #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (16)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .estimate_o      (estimate_o),
    .error_variance_o(error_variance_o),
    .gain_o          (gain_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One filter step: optional reload, gain P/(P+R), estimate and variance update.
  function automatic filter_update_t kalman_step(logic signed [DW-1:0] sample,
                                                 logic restart);
    logic [DW:0]          denom;
    logic [63:0]          ratio, mag, correction, var_drop, next_var;
    logic signed [63:0]   s_wide, e_wide, innovation, next_est;
    logic [GAIN_BITS-1:0] gain;
    filter_update_t       upd;
    if (restart) begin
      est_state = start_est_reg;
      var_state = start_var_reg;
      restarts_seen++;
    end
    denom = var_state + meas_noise_reg;
    if (denom == '0) begin
      gain = '0;
    end else begin
      ratio = ({32'b0, var_state} << GAIN_BITS) / {31'b0, denom};
      gain = (ratio > GAIN_MAX) ? '1 : ratio[GAIN_BITS-1:0];
    end

    // The correction is truncated toward zero, so it works on the magnitude.
    s_wide = sample;
    e_wide = est_state;
    innovation = s_wide - e_wide;
    mag = (innovation < 0) ? -innovation : innovation;
    correction = (mag * gain) >> GAIN_BITS;
    next_est = (innovation < 0) ? e_wide - $signed(correction)
                                : e_wide + $signed(correction);
    if (next_est > EST_MAX) next_est = EST_MAX;
    if (next_est < EST_MIN) next_est = EST_MIN;

    var_drop = ({32'b0, var_state} * gain) >> GAIN_BITS;
    next_var = {32'b0, var_state} - var_drop + {32'b0, proc_noise_reg};
    if (next_var > VAR_MAX) begin
      next_var = VAR_MAX;
      var_saturations++;
    end

    est_state = next_est[DW-1:0];
    var_state = next_var[DW-1:0];
    if (gain > gain_peak) gain_peak = gain;
    if (gain < gain_floor) gain_floor = gain;
    upd.estimate = est_state;
    upd.variance = var_state;
    upd.gain = gain;
    return upd;
  endfunction

  // Register values: extremes, small typical noise levels and raw random words.
  function automatic logic [DW-1:0] pick_reg_value();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return $urandom_range(32'h00FF_FFFF, 1);
      3: return $urandom_range(32'h0010_0000, 32'h0000_1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [DW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_MEAS_NOISE: meas_noise_reg = value;
      REG_PROC_NOISE: proc_noise_reg = value;
      REG_START_EST:  start_est_reg = value;
      REG_START_VAR:  start_var_reg = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_settings(logic [DW-1:0] r, logic [DW-1:0] q,
                               logic [DW-1:0] est0, logic [DW-1:0] var0);
    write_reg(REG_MEAS_NOISE, r);
    write_reg(REG_PROC_NOISE, q);
    write_reg(REG_START_EST, est0);
    write_reg(REG_START_VAR, var0);
    settings_loaded++;
  endtask

  task automatic enqueue_sample(logic [DW-1:0] s, logic r);
    sample_queue.push_back('{sample: s, restart: r});
    items_queued++;
  endtask

  // Waits until every queued item has been taken and
  // every predicted update has come back.
  task automatic wait_until_idle();
    do @(posedge clk_i);
    while (items_sent != items_queued || predicted_updates.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Stimulus: directed corner cases first, then random-walk runs per setting.
  initial begin
    int unsigned  phase, queued, run_len, k, spread;
    logic [DW-1:0] level;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of all registers, sample extremes and a restart.
    wait_until_idle();
    enqueue_sample(32'h0000_0000, 1'b0);
    enqueue_sample(32'h7FFF_FFFF, 1'b0);
    enqueue_sample(32'h8000_0000, 1'b0);
    enqueue_sample(32'h0001_0000, 1'b0);
    enqueue_sample(32'hFFFF_0000, 1'b1);

    // Zero R with zero P: the gain is zero.
    wait_until_idle();
    load_settings(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0);
    enqueue_sample(32'h8000_0000, 1'b1);
    enqueue_sample(32'h0000_0000, 1'b0);

    // Zero R and zero start P, then P grows by Q: the gain saturates at its top.
    wait_until_idle();
    load_settings(32'h0, 32'h0001_0000, 32'h0, 32'h0);
    enqueue_sample(32'h0005_0000, 1'b1);
    enqueue_sample(32'h8000_0000, 1'b0);
    enqueue_sample(32'h7FFF_FFFF, 1'b0);

    // Smallest R, largest Q and P: the variance saturates.
    wait_until_idle();
    load_settings(32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    enqueue_sample(32'h7FFF_FFFF, 1'b1);
    enqueue_sample(32'h8000_0000, 1'b0);
    enqueue_sample(32'h1234_5678, 1'b0);

    // Largest R with a tiny P: the gain is almost zero.
    wait_until_idle();
    load_settings(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h1);
    enqueue_sample(32'h8000_0000, 1'b1);
    enqueue_sample(32'h0000_0000, 1'b0);
    enqueue_sample(32'hFFFF_FFFF, 1'b0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_until_idle();
      send_idle_max = (phase == 3 || phase == 6) ? 0 : 14;
      recv_idle_max = (phase == 3 || phase == 5) ? 0 : 14;
      load_settings(pick_reg_value(), pick_reg_value(), $urandom, pick_reg_value());
      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        if ($urandom_range(9, 0) == 0) begin
          // Stray item with arbitrary content.
          enqueue_sample($urandom, 1'($urandom));
          queued++;
        end else begin
          // A noisy random walk, mostly started by a restart.
          run_len = $urandom_range(30, 4);
          spread = 1 << $urandom_range(24, 2);
          level = $urandom_range(1, 0) ? start_est_reg : $urandom;
          for (k = 0; k < run_len; k++) begin
            enqueue_sample(level + ($urandom % (2 * spread)) - spread,
                           (k == 0) && ($urandom_range(7, 0) != 0));
            level = level + ($urandom % spread) - (spread / 2);
          end
          queued += run_len;
        end
      end
    end

    wait_until_idle();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d items (%0d restarts) under %0d register settings.",
             items_sent, restarts_seen, settings_loaded);
    $display("Gain spanned %0d to %0d; the variance saturated %0d times.",
             gain_floor, gain_peak, var_saturations);
    if (fail_count == 0) begin
      $display("PASS scalar_kalman_filter");
    end else begin
      $display("FAIL scalar_kalman_filter");
    end
    $finish;
  end

  // Sender: offers queued items, with a random gap after each one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_updates.push_back(kalman_step(sample_i, restart_i));
        items_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid_i <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          next_item = sample_queue.pop_front();
          sample_i <= next_item.sample;
          restart_i <= next_item.restart;
          in_valid_i <= 1'b1;
          send_wait <= $urandom_range(send_idle_max, 0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result item and stalls at random, now and then for long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_wait <= 0;
    end else if (out_valid_o && out_ready_i) begin
      if (predicted_updates.size() == 0) begin
        $error("result item with no prediction waiting");
        fail_count++;
      end else begin
        want = predicted_updates.pop_front();
        if (estimate_o !== want.estimate) begin
          $error("estimate: expected %0d, got %0d", want.estimate, estimate_o);
          fail_count++;
        end
        if (error_variance_o !== want.variance) begin
          $error("error_variance: expected %0d, got %0d", want.variance, error_variance_o);
          fail_count++;
        end
        if (gain_o !== want.gain) begin
          $error("gain: expected %0d, got %0d", want.gain, gain_o);
          fail_count++;
        end
      end
      results_seen++;
      hold_len = (results_seen % 350 == 40) ? LONG_HOLD : $urandom_range(recv_idle_max, 0);
      if (hold_len == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        recv_wait <= hold_len;
      end
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      out_ready_i <= (recv_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL scalar_kalman_filter");
      $finish;
    end
  end

endmodule
